### design/kfti_pkg.sv
// kfti_pkg: commands, status codes and shared types of the keyframe table interpolator.
// No dependencies.
package kfti_pkg;
  localparam logic [1:0] CMD_FIND     = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_EVAL     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_MATCHED   = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EVALUATED = 3'd5;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

### design/keyframe_table_interpolator.sv
// keyframe_table_interpolator: sorted keyframe table in two RAMs with a scan/shift sequencer.
// Depends on kfti_pkg and kfti_divider.
//
//  channel  | handshake      | payload
//  in       | in_valid/stall | cmd, key_time, key_value
//  out      | out_valid/stall| status, result_value, slot_index
//  cfg      | cfg_we         | cfg_wdata (match_tolerance)
//
// One transaction at a time. Scan reads each entry through the registered RAM read
// port (S_RD, S_CHK); insert/delete shift moves each entry with a read and a write
// (S_SRD, S_SWR); evaluate with two neighbors adds a multiply and a serial divide. The
// longest transaction is an insert at the front of a nearly full table.
// Reset empties the table (count zero) at once. A stalled result holds in the output
// register while the next transaction is accepted; that one waits to commit its result.
module keyframe_table_interpolator #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] key_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] result_value,
  output logic [5:0]         slot_index
);
  localparam int AW = $clog2(MAX_KEYFRAMES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_KEYFRAMES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SWR   = 4'd4;
  localparam logic [3:0] S_PUT   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;

  logic [31:0] tol;
  logic [3:0]  state;
  logic [CW-1:0] count;
  logic [1:0]  c_cmd;
  logic [31:0] c_time;
  logic signed [31:0] c_val;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic        pos_found;
  logic        has_prev, has_next;
  logic [31:0] p_time, n_time;
  logic signed [31:0] p_val, n_val;
  logic        neg;
  logic [2:0]  r_status;
  logic signed [31:0] r_val;
  logic [5:0]  r_slot;
  logic [2:0]  o_status;
  logic signed [31:0] o_val;
  logic [5:0]  o_slot;

  logic [31:0] mem_t [MAX_KEYFRAMES];
  logic [31:0] mem_v [MAX_KEYFRAMES];
  logic [AW-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wt, wv, rt;
  logic signed [31:0] rv;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_t[waddr] <= wt;
      mem_v[waddr] <= wv;
    end
    rt <= mem_t[raddr];
    rv <= mem_v[raddr];
  end

  kfti_pkg::div_req_t dreq;
  kfti_pkg::div_rsp_t drsp;
  kfti_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [32:0] diff;
  logic [32:0] adiff;
  logic        tmatch;
  logic signed [32:0] dv;
  logic [32:0] mag;
  logic [63:0] prod;
  logic [63:0] prod_r;
  logic        prod_ok;
  logic        div_wait;
  logic signed [32:0] res33;

  assign diff = 33'(rv) - 33'(c_val);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign tmatch = (rt == c_time);
  assign dv = 33'(n_val) - 33'(p_val);
  assign mag = dv[32] ? 33'(-dv) : 33'(dv);
  assign prod = 64'(mag) * 64'(c_time - p_time);
  assign res33 = neg ? 33'(p_val) - 33'(drsp.quotient[32:0])
                     : 33'(p_val) + 33'(drsp.quotient[32:0]);

  assign in_stall = (state != S_IDLE);
  assign status = o_status;
  assign result_value = o_val;
  assign slot_index = o_slot;

  always_comb begin
    raddr = idx[AW-1:0];
    we = 1'b0;
    waddr = idx[AW-1:0];
    wt = rt;
    wv = rv;
    dreq.start = 1'b0;
    dreq.dividend = prod_r;
    dreq.divisor = {1'b0, n_time - p_time};
    unique case (state)
      S_SWR: begin
        we = 1'b1;
        waddr = (c_cmd == kfti_pkg::CMD_FIND) ? AW'(idx + CW'(1)) : AW'(idx - CW'(1));
      end
      S_PUT: begin
        we = (c_cmd == kfti_pkg::CMD_FIND);
        waddr = pos[AW-1:0];
        wt = c_time;
        wv = c_val;
      end
      S_DIV: dreq.start = prod_ok && !div_wait;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tol <= '0;
      out_valid <= 1'b0;
      prod_ok <= 1'b0;
      div_wait <= 1'b0;
    end else begin
      if (cfg_we) tol <= cfg_wdata;
      if (state == S_PUSH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        o_status <= r_status;
        o_val <= r_val;
        o_slot <= r_slot;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          c_cmd <= cmd;
          c_time <= key_time;
          c_val <= key_value;
          idx <= '0;
          pos <= count;
          pos_found <= 1'b0;
          has_prev <= 1'b0;
          has_next <= 1'b0;
          state <= (cmd == kfti_pkg::CMD_RESERVED) ? S_DONE : S_RD;
          r_status <= kfti_pkg::ST_NOT_FOUND;
          r_val <= '0;
          r_slot <= '0;
        end
        S_RD: begin
          if (idx < count) state <= S_CHK;
          else if (c_cmd == kfti_pkg::CMD_FIND) state <= S_PUT;
          else state <= S_DONE;
        end
        S_CHK: begin
          state <= S_RD;
          idx <= idx + CW'(1);
          unique case (c_cmd)
            kfti_pkg::CMD_FIND: begin
              if (!pos_found && rt > c_time) begin
                pos <= idx;
                pos_found <= 1'b1;
              end
              if (tmatch && adiff <= {1'b0, tol}) begin
                r_status <= kfti_pkg::ST_MATCHED;
                r_val <= rv;
                r_slot <= 6'(idx);
                state <= S_PUSH;
              end else if (idx + CW'(1) == count) begin
                if (count >= MAXC) begin
                  r_status <= kfti_pkg::ST_FULL;
                  state <= S_PUSH;
                end else begin
                  idx <= count - CW'(1);
                  state <= (pos_found || rt > c_time) ? S_SRD : S_PUT;
                end
              end
            end
            kfti_pkg::CMD_DELETE: begin
              if (tmatch && rv == c_val) begin
                r_status <= kfti_pkg::ST_DELETED;
                r_val <= c_val;
                r_slot <= 6'(idx);
                pos <= idx;
                idx <= idx + CW'(1);
                state <= S_SRD;
              end
            end
            default: begin
              if (rt < c_time) begin
                has_prev <= 1'b1;
                p_time <= rt;
                p_val <= rv;
              end
              if (rt > c_time) begin
                has_next <= 1'b1;
                n_time <= rt;
                n_val <= rv;
                state <= S_DIV;
              end
            end
          endcase
        end
        S_SRD: begin
          if (c_cmd == kfti_pkg::CMD_FIND) begin
            state <= (idx + CW'(1) > pos) ? S_SWR : S_PUT;
          end else begin
            state <= (idx < count) ? S_SWR : S_PUT;
          end
        end
        S_SWR: begin
          if (c_cmd == kfti_pkg::CMD_FIND) begin
            if (idx == pos) state <= S_PUT;
            else begin
              idx <= idx - CW'(1);
              state <= S_SRD;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= S_SRD;
          end
        end
        S_PUT: begin
          if (c_cmd == kfti_pkg::CMD_FIND) begin
            r_status <= kfti_pkg::ST_INSERTED;
            r_val <= c_val;
            r_slot <= 6'(pos);
            count <= count + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
          state <= S_PUSH;
        end
        S_DIV: begin
          if (!prod_ok) begin
            prod_r <= prod;
            neg <= dv[32];
            prod_ok <= 1'b1;
            if (!has_prev) begin
              state <= S_DONE;
              prod_ok <= 1'b0;
            end
          end else if (drsp.done) begin
            r_val <= 32'(res33);
            prod_ok <= 1'b0;
            div_wait <= 1'b0;
            state <= S_DONE;
          end else begin
            div_wait <= 1'b1;
          end
        end
        S_DONE: begin
          if (c_cmd == kfti_pkg::CMD_EVAL) begin
            r_status <= kfti_pkg::ST_EVALUATED;
            if (!(has_prev && has_next)) begin
              if (has_next) r_val <= n_val;
              else if (has_prev) r_val <= p_val;
              else r_val <= '0;
            end
          end
          state <= S_PUSH;
        end
        S_PUSH: if (!out_valid || !out_stall) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("count over capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) && !$past(rst) |-> $past(state) == S_PUT)
    else $error("count changed outside commit");
`endif
endmodule

### design/kfti_divider.sv
// kfti_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on kfti_pkg.
module kfti_divider (
  input  logic                clk,
  input  logic                rst,
  input  kfti_pkg::div_req_t  req,
  output kfti_pkg::div_rsp_t  rsp
);
  logic        busy;
  logic        done;
  logic [6:0]  count;
  logic [63:0] quot;
  logic [32:0] divisor;
  logic [33:0] rem;
  logic [33:0] trial;

  assign trial = {rem[32:0], quot[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 7'd0;
        quot <= req.dividend;
        divisor <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem <= {rem[32:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quot};
endmodule

### sim/keyframe_table_interpolator_test.sv
// Self-checking testbench for keyframe_table_interpolator: a directed command table, then
// random find/insert, delete, evaluate and reserved traffic, checked against a local keyframe table.
// Depends on kfti_pkg and the keyframe_table_interpolator RTL.
`timescale 1ns / 100ps

module keyframe_table_interpolator_test;
  localparam int DEPTH = 64;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 100;
  localparam int HOLD_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [5:0]         slot;
  } kf_answer_t;

  typedef struct {
    logic [1:0]         op;
    logic [31:0]        t;
    logic signed [31:0] v;
    logic               typed;
    kf_answer_t         ans;
  } kf_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cmd = kfti_pkg::CMD_FIND;
  logic [31:0] key_time = '0;
  logic signed [31:0] key_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic signed [31:0] result_value;
  logic [5:0] slot_index;

  keyframe_table_interpolator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .key_time(key_time),
    .key_value(key_value), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_value(result_value), .slot_index(slot_index)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [31:0] kf_time [DEPTH];
  logic signed [31:0] kf_val [DEPTH];
  int kf_count = 0;
  logic [31:0] tolerance = 0;
  kf_answer_t pending_answers[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_req = 0;
  bit hold_ack = 0;
  int hold_left = 0;
  int rx_wait = 0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  function automatic kf_answer_t apply_command(input logic [1:0] op, input logic [31:0] t,
                                               input logic signed [31:0] v);
    kf_answer_t a;
    longint d, pv, dv, mag, q;
    int pos, pi, ni;
    a = '{kfti_pkg::ST_NOT_FOUND, 0, 0};
    if (op == kfti_pkg::CMD_FIND) begin
      for (int i = 0; i < kf_count; i++) begin
        d = longint'(kf_val[i]) - longint'(v);
        if (d < 0) d = -d;
        if (kf_time[i] == t && d <= longint'({32'b0, tolerance}))
          return '{kfti_pkg::ST_MATCHED, kf_val[i], i[5:0]};
      end
      if (kf_count >= DEPTH) return '{kfti_pkg::ST_FULL, 0, 0};
      pos = 0;
      while (pos < kf_count && kf_time[pos] <= t) pos++;
      for (int i = kf_count; i > pos; i--) begin
        kf_time[i] = kf_time[i-1];
        kf_val[i] = kf_val[i-1];
      end
      kf_time[pos] = t;
      kf_val[pos] = v;
      kf_count++;
      a = '{kfti_pkg::ST_INSERTED, v, pos[5:0]};
    end else if (op == kfti_pkg::CMD_DELETE) begin
      for (int i = 0; i < kf_count; i++) begin
        if (kf_time[i] == t && kf_val[i] == v) begin
          for (int j = i; j + 1 < kf_count; j++) begin
            kf_time[j] = kf_time[j+1];
            kf_val[j] = kf_val[j+1];
          end
          kf_count--;
          return '{kfti_pkg::ST_DELETED, v, i[5:0]};
        end
      end
    end else if (op == kfti_pkg::CMD_EVAL) begin
      pi = -1;
      ni = -1;
      for (int i = kf_count - 1; i >= 0; i--)
        if (kf_time[i] < t) begin pi = i; break; end
      for (int i = 0; i < kf_count; i++)
        if (kf_time[i] > t) begin ni = i; break; end
      a = '{kfti_pkg::ST_EVALUATED, 0, 0};
      if (pi >= 0 && ni < 0) a.value = kf_val[pi];
      else if (pi < 0 && ni >= 0) a.value = kf_val[ni];
      else if (pi >= 0) begin
        pv = kf_val[pi];
        dv = longint'(kf_val[ni]) - pv;
        mag = dv < 0 ? -dv : dv;
        q = longint'((64'(mag) * 64'(t - kf_time[pi])) / 64'(kf_time[ni] - kf_time[pi]));
        a.value = 32'(pv + (dv < 0 ? -q : q));
      end
    end
    return a;
  endfunction

  // Output side: a random wait per transaction, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) rx_wait <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    kf_answer_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) report("unexpected transaction", status, -1);
      else begin
        w = pending_answers.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (result_value !== w.value) report("result_value", result_value, w.value);
        if (slot_index !== w.slot) report("slot_index", slot_index, w.slot);
      end
    end
  end

  task automatic send_expect(input logic [1:0] op, input logic [31:0] t,
                             input logic signed [31:0] v, input int gap,
                             input logic typed, input kf_answer_t want);
    kf_answer_t a;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    cmd <= op;
    key_time <= t;
    key_value <= v;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    a = apply_command(op, t, v);
    pending_answers = {pending_answers, (typed ? want : a)};
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] t, input logic signed [31:0] v,
                      input int gap);
    send_expect(op, t, v, gap, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_tolerance(input logic [31:0] tol);
    drain();
    cfg_we <= 1;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_we <= 0;
    tolerance = tol;
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) << 16;
      1: return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      2: return (kf_count > 0) ? kf_time[$urandom_range(0, kf_count - 1)] : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  kf_row_t directed[] = '{
    '{kfti_pkg::CMD_EVAL, 32'h0001_0000, 0, 1, '{kfti_pkg::ST_EVALUATED, 0, 0}},
    '{kfti_pkg::CMD_DELETE, 32'h0001_0000, 5, 1, '{kfti_pkg::ST_NOT_FOUND, 0, 0}},
    '{kfti_pkg::CMD_RESERVED, 32'hFFFF_FFFF, -1, 1, '{kfti_pkg::ST_NOT_FOUND, 0, 0}},
    '{kfti_pkg::CMD_FIND, 32'h0000_0000, 32'sh8000_0000, 1,
      '{kfti_pkg::ST_INSERTED, 32'sh8000_0000, 0}},
    '{kfti_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1,
      '{kfti_pkg::ST_INSERTED, 32'sh7FFF_FFFF, 1}},
    '{kfti_pkg::CMD_FIND, 32'h0000_0000, 32'sh8000_0000, 1,
      '{kfti_pkg::ST_MATCHED, 32'sh8000_0000, 0}},
    '{kfti_pkg::CMD_EVAL,   32'h8000_0000, 0, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_EVAL,   32'h0000_0000, 0, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_EVAL,   32'hFFFF_FFFF, 0, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_FIND,   32'h0002_0000, 32'sh0001_0000, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_FIND,   32'h0002_0000, 32'sh0001_0001, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_EVAL,   32'h0002_0000, 0, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_EVAL,   32'h0001_8000, 0, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_DELETE, 32'h0002_0000, 32'sh0001_0000, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_DELETE, 32'h0000_0000, 32'sh8000_0000, 0, '{0, 0, 0}},
    '{kfti_pkg::CMD_EVAL,   32'h0000_0001, 0, 0, '{0, 0, 0}}
  };

  initial begin
    int burst, i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (directed[k])
      send_expect(directed[k].op, directed[k].t, directed[k].v, $urandom_range(0, 3),
                  directed[k].typed, directed[k].ans);

    set_tolerance(32'hFFFF_FFFF);
    send(kfti_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'sh8000_0000, 0);
    set_tolerance(32'h0000_0100);

    // fill to capacity then overflow
    while (kf_count < DEPTH) send(kfti_pkg::CMD_FIND, $urandom, $urandom, 0);
    send(kfti_pkg::CMD_FIND, 32'h1234_0000, 32'sh0000_7777, 0);
    send(kfti_pkg::CMD_EVAL, $urandom, 0, 0);

    // receiver holds off while offers keep coming
    hold_req = !hold_req;
    for (i = 0; i < 6; i++) send(kfti_pkg::CMD_EVAL, $urandom, 0, 0);
    drain();

    for (i = 0; i < 600; i++) begin
      if (i == 200) set_tolerance(32'h0000_0000);
      if (i == 400) set_tolerance($urandom);
      burst = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(kfti_pkg::CMD_FIND, pick_time(), $urandom, burst);
        4: send(kfti_pkg::CMD_FIND, pick_time(),
                (kf_count > 0) ? kf_val[$urandom_range(0, kf_count - 1)] + $urandom_range(0, 300)
                               : $urandom, burst);
        5, 6: begin
          if (kf_count > 0 && $urandom_range(0, 3) != 0) begin
            int j;
            j = $urandom_range(0, kf_count - 1);
            send(kfti_pkg::CMD_DELETE, kf_time[j], kf_val[j], burst);
          end else send(kfti_pkg::CMD_DELETE, pick_time(), $urandom, burst);
        end
        7, 8: send(kfti_pkg::CMD_EVAL, pick_time() + $urandom_range(0, 3) - 1, $urandom, burst);
        default: send($urandom_range(0, 1) ? kfti_pkg::CMD_RESERVED : kfti_pkg::CMD_EVAL,
                      $urandom, $urandom, burst);
      endcase
    end

    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
